// ===== rtl/core/depl_pkg.sv =====
// Package for the double-ended position list: request and response types,
// command and status codes, and shared constants. No dependencies.
package depl_pkg;

	// Default number of entries held by the list.
	localparam int unsigned CAPACITY_DEF = 256;

	// Field widths fixed by the interface.
	localparam int unsigned COORD_W = 8;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned SIZE_W  = 9;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned STAT_W  = 2;

	// Command codes; code 7 is unused and acts as no operation.
	typedef enum logic [CMD_W-1:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_REM_HEAD = 3'd2,
		CMD_REM_TAIL = 3'd3,
		CMD_RD_HEAD  = 3'd4,
		CMD_RD_TAIL  = 3'd5,
		CMD_RD_IDX   = 3'd6
	} cmd_t;

	// Status codes returned with every response.
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} stat_t;

	// One stored entry.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] sym;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// Request payload.
	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [COORD_W-1:0] in_x;
		logic [COORD_W-1:0] in_y;
		logic [COORD_W-1:0] in_symbol;
		logic [INDEX_W-1:0] index;
	} req_t;

	// Response payload.
	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic [COORD_W-1:0] out_symbol;
		logic [SIZE_W-1:0]  size;
		logic [STAT_W-1:0]  status;
	} rsp_t;

	// Memory port controls.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// What a request leaves for the response stage while the read is in flight.
	typedef struct packed {
		logic              rd_ok;
		logic [SIZE_W-1:0] size;
		stat_t             status;
	} info_t;

endpackage

// ===== rtl/core/depl_mem.sv =====
// Entry storage: one synchronous memory with a single address and a
// registered read. Depends on depl_pkg.
module depl_mem #(
	parameter int unsigned DEPTH = depl_pkg::CAPACITY_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  depl_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]      addr,
	input  depl_pkg::entry_t   wdata,
	output depl_pkg::entry_t   rdata
);

	depl_pkg::entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/core/depl_ctrl.sv =====
// Command decode with the head pointer and count registers; computes the
// memory slot for each request. Depends on depl_pkg.
module depl_ctrl #(
	parameter int unsigned CAPACITY = depl_pkg::CAPACITY_DEF,
	parameter int unsigned PTR_W    = $clog2(CAPACITY),
	parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  depl_pkg::req_t     req,
	input  logic               accept,
	output depl_pkg::mem_ctl_t mem_ctl,
	output logic [PTR_W-1:0]   mem_addr,
	output depl_pkg::entry_t   mem_wdata,
	output depl_pkg::info_t    info
);

	localparam int unsigned CMP_W = (CNT_W > depl_pkg::INDEX_W) ? CNT_W : depl_pkg::INDEX_W;

	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_nx;
	logic [CNT_W-1:0] count_nx;
	logic [PTR_W-1:0] head_dec;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] pos;
	logic [PTR_W:0]   slot_sum;
	logic [PTR_W-1:0] slot;
	logic             use_dec;
	logic             wr;
	logic             rd;
	logic             full;
	logic             empty;
	depl_pkg::stat_t  status;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// Head pointer steps with wrap at the capacity.
	assign head_dec = (head_q == '0) ? PTR_W'(CAPACITY - 1) : head_q - PTR_W'(1);
	assign head_inc = (head_q == PTR_W'(CAPACITY - 1)) ? '0 : head_q + PTR_W'(1);

	// Slot of a position from the head; both terms are below the capacity.
	assign slot_sum = {1'b0, head_q} + {1'b0, pos};
	assign slot     = (slot_sum >= (PTR_W+1)'(CAPACITY))
		? PTR_W'(slot_sum - (PTR_W+1)'(CAPACITY)) : PTR_W'(slot_sum);

	// Decode the command into state updates and at most one memory access.
	always_comb begin
		head_nx  = head_q;
		count_nx = count_q;
		pos      = '0;
		use_dec  = 1'b0;
		wr       = 1'b0;
		rd       = 1'b0;
		status   = depl_pkg::ST_OK;
		case (depl_pkg::cmd_t'(req.command))
			depl_pkg::CMD_INS_HEAD: begin
				if (full) begin
					status = depl_pkg::ST_FULL;
				end else begin
					head_nx  = head_dec;
					count_nx = count_q + CNT_W'(1);
					use_dec  = 1'b1;
					wr       = 1'b1;
				end
			end
			depl_pkg::CMD_INS_TAIL: begin
				if (full) begin
					status = depl_pkg::ST_FULL;
				end else begin
					pos      = PTR_W'(count_q);
					count_nx = count_q + CNT_W'(1);
					wr       = 1'b1;
				end
			end
			depl_pkg::CMD_REM_HEAD: begin
				if (empty) begin
					status = depl_pkg::ST_EMPTY;
				end else begin
					head_nx  = head_inc;
					count_nx = count_q - CNT_W'(1);
				end
			end
			depl_pkg::CMD_REM_TAIL: begin
				if (empty) begin
					status = depl_pkg::ST_EMPTY;
				end else begin
					count_nx = count_q - CNT_W'(1);
				end
			end
			depl_pkg::CMD_RD_HEAD: begin
				if (empty) begin
					status = depl_pkg::ST_EMPTY;
				end else begin
					rd = 1'b1;
				end
			end
			depl_pkg::CMD_RD_TAIL: begin
				if (empty) begin
					status = depl_pkg::ST_EMPTY;
				end else begin
					pos = PTR_W'(count_q - CNT_W'(1));
					rd  = 1'b1;
				end
			end
			depl_pkg::CMD_RD_IDX: begin
				if (CMP_W'(req.index) >= CMP_W'(count_q)) begin
					status = depl_pkg::ST_RANGE;
				end else begin
					pos = PTR_W'(req.index);
					rd  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Memory access happens only for an accepted request.
	assign mem_ctl.wr_en = wr & accept;
	assign mem_ctl.rd_en = rd & accept;
	assign mem_addr      = use_dec ? head_dec : slot;
	assign mem_wdata     = '{x: req.in_x, y: req.in_y, sym: req.in_symbol};

	assign info.rd_ok  = rd;
	assign info.size   = depl_pkg::SIZE_W'(count_nx);
	assign info.status = status;

	// Pointer and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_nx;
			count_q <= count_nx;
		end
	end

endmodule

// ===== rtl/core/depl_resp.sv =====
// Response path: holds request info while the memory read completes, then
// forms the response in an output register. Depends on depl_pkg.
module depl_resp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  depl_pkg::info_t  info,
	input  depl_pkg::entry_t rdata,
	output logic             can_accept,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output depl_pkg::rsp_t   rsp
);

	logic            valid_s1;
	depl_pkg::info_t info_s1;
	logic            advance;
	logic            out_valid_q;
	depl_pkg::rsp_t  rsp_q;

	// Move the read stage forward whenever the output register is free.
	assign advance    = valid_s1 && (!out_valid_q || rsp_ready);
	assign can_accept = !valid_s1 || advance;

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; entry fields are zero unless a read succeeded.
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.out_x      <= info_s1.rd_ok ? rdata.x   : '0;
			rsp_q.out_y      <= info_s1.rd_ok ? rdata.y   : '0;
			rsp_q.out_symbol <= info_s1.rd_ok ? rdata.sym : '0;
			rsp_q.size       <= info_s1.size;
			rsp_q.status     <= info_s1.status;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/double_ended_position_list.sv =====
// Top level of the double-ended position list: control, entry memory and
// response path. Depends on depl_pkg, depl_ctrl, depl_mem and depl_resp.
//
//   Channel   Direction   Handshake              Payload
//   req       in          req_valid / req_ready  depl_pkg::req_t
//   rsp       out         rsp_valid / rsp_ready  depl_pkg::rsp_t
//
// One request is accepted per cycle while req_ready is high; its response passes
// through the entry memory read and then the output register.
// Each request makes at most one access to the single memory port.
// Reset clears the head pointer and count; the memory itself is not cleared.
// A held response stalls the read stage, and then req_ready drops.
module double_ended_position_list #(
	parameter int unsigned CAPACITY = depl_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  depl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output depl_pkg::rsp_t rsp
);

	localparam int unsigned PTR_W = $clog2(CAPACITY);

	logic               accept;
	depl_pkg::mem_ctl_t mem_ctl;
	logic [PTR_W-1:0]   mem_addr;
	depl_pkg::entry_t   mem_wdata;
	depl_pkg::entry_t   mem_rdata;
	depl_pkg::info_t    info;

	assign accept = req_valid && req_ready;

	depl_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.accept    (accept),
		.mem_ctl   (mem_ctl),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.info      (info)
	);

	depl_mem #(
		.DEPTH (CAPACITY),
		.AW    (PTR_W)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	depl_resp u_resp (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.info       (info),
		.rdata      (mem_rdata),
		.can_accept (req_ready),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

// ===== rtl/core/depl_checker.sv =====
// Port-level checks for the double-ended position list, bound to the top
// level. Depends on depl_pkg and double_ended_position_list.
module depl_checker #(
	parameter int unsigned CAPACITY = depl_pkg::CAPACITY_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input depl_pkg::rsp_t rsp
);

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// The reported size never exceeds the capacity.
	a_size_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.size <= depl_pkg::SIZE_W'(CAPACITY))
		else $error("size beyond capacity");

	// A full flag comes only with a full list.
	a_full_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == depl_pkg::ST_FULL |->
		rsp.size == depl_pkg::SIZE_W'(CAPACITY))
		else $error("full status with list not full");

	// An empty flag comes only with an empty list.
	a_empty_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == depl_pkg::ST_EMPTY |-> rsp.size == '0)
		else $error("empty status with entries present");

	// A failed request returns no entry data.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != depl_pkg::ST_OK |->
		rsp.out_x == '0 && rsp.out_y == '0 && rsp.out_symbol == '0)
		else $error("entry data on failed request");

endmodule

bind double_ended_position_list depl_checker #(.CAPACITY(CAPACITY)) u_chk (.*);

// ===== dv/double_ended_position_list_tb.sv =====
// Testbench for double_ended_position_list: random and directed requests checked
// against an in-bench model of the circular list. Depends on depl_pkg and the RTL.
module double_ended_position_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = depl_pkg::CAPACITY_DEF;
	localparam logic [depl_pkg::CMD_W-1:0] CMD_NOP = 3'd7;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	depl_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	depl_pkg::rsp_t rsp;

	double_ended_position_list #(.CAPACITY(CAP)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Model of the list contents.
	depl_pkg::entry_t list_mem [CAP];
	int     list_head = 0;
	int     list_count = 0;
	int     peak_count = 0;

	// Responses predicted but not yet seen.
	depl_pkg::rsp_t pending_rsp [$];

	// Run bookkeeping.
	int     cycle_cnt = 0;
	int     mismatch_cnt = 0;
	int     req_cnt = 0;
	int     rsp_cnt = 0;
	int     full_cnt = 0;
	int     empty_cnt = 0;
	int     range_cnt = 0;

	// Knobs for the sender and receiver, set by the tests.
	int     tx_gap_max = 0;
	int     tx_burst_left = 0;
	int     rx_mode = 0;
	bit     hold_go = 1'b0;
	int     hold_cnt = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the list model by one request and return the response it gives.
	function automatic depl_pkg::rsp_t apply_request(depl_pkg::req_t r);
		depl_pkg::rsp_t   o;
		depl_pkg::entry_t e;
		o = '0;
		e = '{x: r.in_x, y: r.in_y, sym: r.in_symbol};
		case (r.command)
			depl_pkg::CMD_INS_HEAD: begin
				if (list_count >= CAP) begin
					o.status = depl_pkg::ST_FULL;
				end else begin
					list_head = (list_head + CAP - 1) % CAP;
					list_mem[list_head] = e;
					list_count++;
				end
			end
			depl_pkg::CMD_INS_TAIL: begin
				if (list_count >= CAP) begin
					o.status = depl_pkg::ST_FULL;
				end else begin
					list_mem[(list_head + list_count) % CAP] = e;
					list_count++;
				end
			end
			depl_pkg::CMD_REM_HEAD: begin
				if (list_count == 0) begin
					o.status = depl_pkg::ST_EMPTY;
				end else begin
					list_head = (list_head + 1) % CAP;
					list_count--;
				end
			end
			depl_pkg::CMD_REM_TAIL: begin
				if (list_count == 0) o.status = depl_pkg::ST_EMPTY;
				else list_count--;
			end
			depl_pkg::CMD_RD_HEAD: begin
				if (list_count == 0) o.status = depl_pkg::ST_EMPTY;
				else e = list_mem[list_head];
			end
			depl_pkg::CMD_RD_TAIL: begin
				if (list_count == 0) o.status = depl_pkg::ST_EMPTY;
				else e = list_mem[(list_head + list_count - 1) % CAP];
			end
			depl_pkg::CMD_RD_IDX: begin
				if (int'(r.index) >= list_count) o.status = depl_pkg::ST_RANGE;
				else e = list_mem[(list_head + int'(r.index)) % CAP];
			end
			default: ;
		endcase
		// Only a successful read returns entry data.
		if (o.status == depl_pkg::ST_OK && (r.command == depl_pkg::CMD_RD_HEAD ||
				r.command == depl_pkg::CMD_RD_TAIL || r.command == depl_pkg::CMD_RD_IDX)) begin
			o.out_x = e.x;
			o.out_y = e.y;
			o.out_symbol = e.sym;
		end
		o.size = list_count[depl_pkg::SIZE_W-1:0];
		if (list_count > peak_count) peak_count = list_count;
		return o;
	endfunction

	// Predict on every accepted request, then check every accepted response.
	always @(posedge clk) begin
		depl_pkg::rsp_t want;
		if (arst_n && req_valid && req_ready) begin
			want = apply_request(req);
			pending_rsp.push_back(want);
			req_cnt++;
			case (want.status)
				depl_pkg::ST_FULL:  full_cnt++;
				depl_pkg::ST_EMPTY: empty_cnt++;
				depl_pkg::ST_RANGE: range_cnt++;
				default: ;
			endcase
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_cnt++;
			if (pending_rsp.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("ERROR: unexpected response x=%h y=%h sym=%h size=%0d st=%0d",
						rsp.out_x, rsp.out_y, rsp.out_symbol, rsp.size, rsp.status);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.out_x !== want.out_x || rsp.out_y !== want.out_y ||
						rsp.out_symbol !== want.out_symbol || rsp.size !== want.size ||
						rsp.status !== want.status) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$write("ERROR: response %0d expected x=%h y=%h sym=%h size=%0d st=%0d, ",
							rsp_cnt, want.out_x, want.out_y, want.out_symbol, want.size,
							want.status);
						$display("got x=%h y=%h sym=%h size=%0d st=%0d",
							rsp.out_x, rsp.out_y, rsp.out_symbol, rsp.size, rsp.status);
					end
				end
			end
		end
	end

	// Receiver: one long hold-off when asked, otherwise always ready or runs of ready and stall.
	always @(posedge clk) begin
		int  run_left;
		bit  run_ready;
		int  ready_pct;
		if (hold_go && hold_cnt < HOLD_CYCLES) begin
			rsp_ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else if (rx_mode == 0) begin
			rsp_ready <= 1'b1;
		end else begin
			if (run_left <= 0) begin
				ready_pct = (rx_mode == 1) ? 75 : 30;
				run_ready = ($urandom_range(99) < ready_pct);
				run_left = $urandom_range(1, 6);
			end
			rsp_ready <= run_ready;
			run_left--;
		end
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d responses outstanding",
				cycle_cnt, pending_rsp.size());
			$display("double_ended_position_list_tb: FAIL");
			$finish;
		end
	end

	function automatic depl_pkg::req_t make_req(logic [depl_pkg::CMD_W-1:0] cmd,
			logic [7:0] x, logic [7:0] y, logic [7:0] s, logic [7:0] idx);
		depl_pkg::req_t r;
		r.command = cmd;
		r.in_x = x;
		r.in_y = y;
		r.in_symbol = s;
		r.index = idx;
		return r;
	endfunction

	// Random request; ins_pct and rem_pct steer the list size up or down.
	function automatic depl_pkg::req_t rand_req(int ins_pct, int rem_pct);
		depl_pkg::req_t r;
		int   roll;
		r = make_req(CMD_NOP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		roll = $urandom_range(99);
		if (roll < ins_pct) begin
			r.command = $urandom_range(1) ? depl_pkg::CMD_INS_HEAD : depl_pkg::CMD_INS_TAIL;
		end else if (roll < ins_pct + rem_pct) begin
			r.command = $urandom_range(1) ? depl_pkg::CMD_REM_HEAD : depl_pkg::CMD_REM_TAIL;
		end else begin
			case ($urandom_range(9))
				0, 1:    r.command = depl_pkg::CMD_RD_HEAD;
				2, 3:    r.command = depl_pkg::CMD_RD_TAIL;
				4:       r.command = CMD_NOP;
				default: r.command = depl_pkg::CMD_RD_IDX;
			endcase
			// Mostly aim the index inside the list.
			if (list_count > 0 && $urandom_range(3) != 0)
				r.index = 8'($urandom_range((list_count > 256 ? 256 : list_count) - 1));
		end
		return r;
	endfunction

	// Offer one request in bursts with random gaps; valid stays high on return.
	task automatic send_req(depl_pkg::req_t r);
		int gap;
		if (tx_burst_left <= 0) begin
			tx_burst_left = $urandom_range(1, 12);
			gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		tx_burst_left--;
	endtask

	// Every remove and read command on an empty list, plus the unused code.
	task automatic test_empty_list();
		send_req(make_req(depl_pkg::CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_REM_TAIL, 8'hff, 8'hff, 8'hff, 8'hff));
		send_req(make_req(depl_pkg::CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_RD_IDX, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_RD_IDX, 8'h00, 8'h00, 8'h00, 8'hff));
		send_req(make_req(CMD_NOP, 8'hff, 8'hff, 8'hff, 8'hff));
	endtask

	// Each command on a short list, with extreme field values.
	task automatic test_each_command();
		send_req(make_req(depl_pkg::CMD_INS_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_INS_TAIL, 8'hff, 8'hff, 8'hff, 8'hff));
		send_req(make_req(depl_pkg::CMD_INS_HEAD, 8'ha5, 8'h5a, 8'h3c, 8'h00));
		send_req(make_req(depl_pkg::CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_RD_IDX, 8'h00, 8'h00, 8'h00, 8'd0));
		send_req(make_req(depl_pkg::CMD_RD_IDX, 8'h00, 8'h00, 8'h00, 8'd1));
		send_req(make_req(depl_pkg::CMD_RD_IDX, 8'h00, 8'h00, 8'h00, 8'd2));
		// An index equal to the size is just out of range.
		send_req(make_req(depl_pkg::CMD_RD_IDX, 8'h00, 8'h00, 8'h00, 8'd3));
		send_req(make_req(CMD_NOP, 8'h12, 8'h34, 8'h56, 8'h78));
		send_req(make_req(depl_pkg::CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_RD_IDX, 8'h00, 8'h00, 8'h00, 8'd0));
		send_req(make_req(depl_pkg::CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// Fill to capacity from both ends, push against the full list, then drain.
	task automatic test_fill_to_capacity();
		int n;
		tx_gap_max = 6;
		rx_mode = 1;
		for (n = 0; n < CAP; n++) begin
			send_req(make_req($urandom_range(1) ? depl_pkg::CMD_INS_HEAD : depl_pkg::CMD_INS_TAIL,
				8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
			if ($urandom_range(7) == 0)
				send_req(make_req(depl_pkg::CMD_RD_IDX, 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom_range(n))));
		end
		// Inserts on a full list are refused.
		send_req(make_req(depl_pkg::CMD_INS_HEAD, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom)));
		send_req(make_req(depl_pkg::CMD_INS_TAIL, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom)));
		send_req(make_req(depl_pkg::CMD_RD_IDX, 8'h00, 8'h00, 8'h00, 8'(CAP - 1)));
		send_req(make_req(depl_pkg::CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(make_req(depl_pkg::CMD_INS_TAIL, 8'hff, 8'hff, 8'hff, 8'hff));
		rx_mode = 2;
		for (n = CAP; n > 0; n--) begin
			send_req(make_req($urandom_range(1) ? depl_pkg::CMD_REM_HEAD : depl_pkg::CMD_REM_TAIL,
				8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
			if ($urandom_range(7) == 0)
				send_req(rand_req(0, 0));
		end
		send_req(make_req(depl_pkg::CMD_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_receiver_hold();
		int n;
		tx_gap_max = 0;
		hold_go = 1'b1;
		for (n = 0; n < 40; n++)
			send_req(rand_req(40, 10));
	endtask

	// Mixed random traffic, drifting the size up and down across several idling styles.
	task automatic test_random_mix();
		int n;
		for (n = 0; n < 320; n++) begin
			case (n / 80)
				0: begin tx_gap_max = 4; rx_mode = 1; end
				1: begin tx_gap_max = 0; rx_mode = 0; end
				2: begin tx_gap_max = 8; rx_mode = 2; end
				default: begin tx_gap_max = 3; rx_mode = 1; end
			endcase
			send_req(rand_req((n / 80) % 2 == 0 ? 55 : 30, (n / 80) % 2 == 0 ? 20 : 45));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_each_command();
		test_fill_to_capacity();
		test_receiver_hold();
		test_random_mix();

		// Drain what is still in flight.
		req_valid <= 1'b0;
		rx_mode = 1;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Summary: %0d requests, %0d responses; peak size %0d of %0d entries.",
			req_cnt, rsp_cnt, peak_count, CAP);
		$display("Summary: %0d full inserts, %0d empty operations, %0d out-of-range reads.",
			full_cnt, empty_cnt, range_cnt);
		if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
			$display("double_ended_position_list_tb: PASS");
		end else begin
			$display("ERROR: %0d mismatches, %0d responses missing",
				mismatch_cnt, pending_rsp.size());
			$display("double_ended_position_list_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/depl_pkg.sv
rtl/core/depl_mem.sv
rtl/core/depl_ctrl.sv
rtl/core/depl_resp.sv
rtl/core/double_ended_position_list.sv
rtl/core/depl_checker.sv
dv/double_ended_position_list_tb.sv
